@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every clock edge outside reset.
`define BDQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check prop in the cycle after trig holds.
`define BDQ_ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error(msg);

`endif

@@ hdl/bdq_pkg.sv @@
`timescale 1ns / 1ps

package bdq_pkg;

   localparam int ACTION_W = 3;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_HEAD = 3'd0,
      ACT_PUSH_TAIL = 3'd1,
      ACT_POP_HEAD  = 3'd2,
      ACT_POP_TAIL  = 3'd3,
      ACT_SEARCH    = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic push_head;
      logic push_tail;
      logic pop_head;
      logic pop_tail;
      logic set_full;
      logic set_empty;
      logic scan_start;
      logic scan_read;
      logic take_pop;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                full;
      logic                empty;
      logic                scan_left;
      logic                scan_busy;
      logic                rsp_open;
   } dp_sts_type;

endpackage

@@ hdl/byte_deque_with_search.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_action, req_value
// rsp       out        rsp_valid/rsp_ready  rsp_data, rsp_found, rsp_status, rsp_count
//
// Pushes, rejected operations and unused codes pass through EXEC and DONE,
// pops through EXEC, READ and DONE, a search through EXEC, SCAN and DONE: the
// scan reads one stored entry per cycle through the single read port of the
// ring memory, and the compare of each entry is registered behind its read.
// One item is in work at a time; the next is taken while a result waits.
// Synchronous reset empties the deque; stored bytes are not cleared.

module byte_deque_with_search #(
   parameter int DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bdq_pkg::ACTION_W-1:0]   req_action,
   input  logic [bdq_pkg::BYTE_W-1:0]     req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bdq_pkg::BYTE_W-1:0]     rsp_data,
   output logic                           rsp_found,
   output logic [bdq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bdq_pkg::COUNT_W-1:0]    rsp_count
);

   import bdq_pkg::*;

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   bdq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   bdq_datapath #(
      .DEPTH(DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_action(req_action),
      .req_value (req_value),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_found (rsp_found),
      .rsp_status(rsp_status),
      .rsp_count (rsp_count)
   );

endmodule

@@ hdl/bdq_ram.sv @@
`timescale 1ns / 1ps

module bdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/bdq_datapath.sv @@
`timescale 1ns / 1ps

module bdq_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bdq_pkg::ctrl_cmd_type          cmd,
   output bdq_pkg::dp_sts_type            sts,
   input  logic [bdq_pkg::ACTION_W-1:0]   req_action,
   input  logic [bdq_pkg::BYTE_W-1:0]     req_value,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [bdq_pkg::BYTE_W-1:0]     rsp_data,
   output logic                           rsp_found,
   output logic [bdq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bdq_pkg::COUNT_W-1:0]    rsp_count
);

   import bdq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_POS  = AW'(DEPTH - 1);
   localparam logic [AW:0]   RING_SIZE = (AW + 1)'(DEPTH);
   localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);

   logic [ACTION_W-1:0] action_ff, action_in;
   logic [BYTE_W-1:0]   value_ff, value_in;
   logic [AW-1:0]       front_ff, front_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [FW-1:0]       remain_ff, remain_in;
   logic                chk_ff, chk_in;
   logic [BYTE_W-1:0]   data_ff, data_in;
   logic                found_ff, found_in;
   status_type          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_found_ff, rsp_found_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [AW-1:0]       front_dec;
   logic [AW-1:0]       front_inc;
   logic [AW-1:0]       ptr_inc;
   logic [FW-1:0]       fill_less;
   logic [AW-1:0]       offset;
   logic [AW:0]         ring_sum;
   logic [AW-1:0]       ring_addr;
   logic                hit;
   logic                rsp_open;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [BYTE_W-1:0]   rd_data;

   // Ring arithmetic; wrap by compare so depths that are not a power of two work.
   assign front_dec = (front_ff == '0) ? LAST_POS : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_POS) ? '0 : front_ff + 1'b1;
   assign ptr_inc   = (ptr_ff == LAST_POS) ? '0 : ptr_ff + 1'b1;
   assign fill_less = fill_ff - 1'b1;
   assign offset    = cmd.push_tail ? AW'(fill_ff) : AW'(fill_less);
   assign ring_sum  = {1'b0, front_ff} + {1'b0, offset};
   assign ring_addr = (ring_sum >= RING_SIZE) ? AW'(ring_sum - RING_SIZE)
                                              : ring_sum[AW-1:0];

   assign hit      = chk_ff && (rd_data == value_ff);
   assign rsp_open = !rsp_valid_ff || rsp_ready;

   assign wr_en   = cmd.push_head || cmd.push_tail;
   assign wr_addr = cmd.push_head ? front_dec : ring_addr;
   assign rd_en   = cmd.pop_head || cmd.pop_tail || cmd.scan_read;
   assign rd_addr = cmd.scan_read ? ptr_ff : (cmd.pop_head ? front_ff : ring_addr);

   bdq_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(value_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      action_in     = action_ff;
      value_in      = value_ff;
      front_in      = front_ff;
      fill_in       = fill_ff;
      ptr_in        = ptr_ff;
      remain_in     = remain_ff;
      chk_in        = cmd.scan_read;
      data_in       = data_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      if (cmd.accept) begin
         action_in = req_action;
         value_in  = req_value;
         data_in   = '0;
         found_in  = 1'b0;
         status_in = ST_OK;
      end
      if (cmd.push_head) begin
         front_in = front_dec;
         fill_in  = fill_ff + 1'b1;
      end
      if (cmd.push_tail) begin
         fill_in = fill_ff + 1'b1;
      end
      if (cmd.pop_head) begin
         front_in = front_inc;
         fill_in  = fill_less;
      end
      if (cmd.pop_tail) begin
         fill_in = fill_less;
      end
      if (cmd.set_full) begin
         status_in = ST_FULL;
      end
      if (cmd.set_empty) begin
         status_in = ST_EMPTY;
      end
      if (cmd.scan_start) begin
         ptr_in    = front_ff;
         remain_in = fill_ff;
      end
      if (cmd.scan_read) begin
         ptr_in    = ptr_inc;
         remain_in = remain_ff - 1'b1;
      end
      // Compare happens in the cycle after the scan read.
      if (hit) begin
         found_in = 1'b1;
      end
      if (cmd.take_pop) begin
         data_in = rd_data;
      end

      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = data_ff;
         rsp_found_in  = found_ff;
         rsp_status_in = status_ff;
         rsp_count_in  = COUNT_W'(fill_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         fill_ff      <= '0;
         remain_ff    <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         fill_ff      <= fill_in;
         remain_ff    <= remain_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      value_ff      <= value_in;
      ptr_ff        <= ptr_in;
      data_ff       <= data_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      sts.action    = action_ff;
      sts.full      = (fill_ff == FULL_FILL);
      sts.empty     = (fill_ff == '0);
      sts.scan_left = (remain_ff != '0);
      sts.scan_busy = (remain_ff != '0) || chk_ff;
      sts.rsp_open  = rsp_open;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

@@ hdl/bdq_ctrl.sv @@
`timescale 1ns / 1ps

module bdq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bdq_pkg::dp_sts_type   sts,
   output bdq_pkg::ctrl_cmd_type cmd
);

   import bdq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (sts.action)
               ACT_POP_HEAD, ACT_POP_TAIL: begin
                  state_in = sts.empty ? S_DONE : S_READ;
               end
               ACT_SEARCH: begin
                  state_in = S_SCAN;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (!sts.scan_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.rsp_open) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_EXEC: begin
            case (sts.action)
               ACT_PUSH_HEAD: begin
                  cmd.set_full  = sts.full;
                  cmd.push_head = !sts.full;
               end
               ACT_PUSH_TAIL: begin
                  cmd.set_full  = sts.full;
                  cmd.push_tail = !sts.full;
               end
               ACT_POP_HEAD: begin
                  cmd.set_empty = sts.empty;
                  cmd.pop_head  = !sts.empty;
               end
               ACT_POP_TAIL: begin
                  cmd.set_empty = sts.empty;
                  cmd.pop_tail  = !sts.empty;
               end
               ACT_SEARCH: begin
                  cmd.scan_start = 1'b1;
               end
               default: begin
                  cmd = '0;
               end
            endcase
         end
         S_READ: begin
            cmd.take_pop = 1'b1;
         end
         S_SCAN: begin
            cmd.scan_read = sts.scan_left;
         end
         S_DONE: begin
            cmd.finish = sts.rsp_open;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ hdl/bdq_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdq_checker #(
   parameter int DEPTH = 64
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [bdq_pkg::ACTION_W-1:0]   req_action,
   input logic [bdq_pkg::BYTE_W-1:0]     req_value,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bdq_pkg::BYTE_W-1:0]     rsp_data,
   input logic                           rsp_found,
   input logic [bdq_pkg::STATUS_W-1:0]   rsp_status,
   input logic [bdq_pkg::COUNT_W-1:0]    rsp_count
);

   import bdq_pkg::*;

   logic                                        rsp_stall;
   logic [BYTE_W+STATUS_W+COUNT_W:0]            rsp_payload;
   logic                                        req_xfer;
   logic                                        found_ok;
   logic                                        reject_quiet;
   logic                                        full_count;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_payload  = {rsp_data, rsp_found, rsp_status, rsp_count};
   assign req_xfer     = req_valid && req_ready;
   assign found_ok     = !(rsp_valid && rsp_found)
                         || (rsp_status == ST_OK && rsp_data == '0);
   assign reject_quiet = !(rsp_valid && rsp_status != ST_OK)
                         || (rsp_data == '0 && !rsp_found);
   assign full_count   = !(rsp_valid && rsp_status == ST_FULL)
                         || (rsp_count == COUNT_W'(DEPTH));

   // A stalled result keeps its payload.
   `BDQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_valid && $stable(rsp_payload), "result changed while stalled")

   // Only one item in work: a transfer on req closes the channel next cycle.
   `BDQ_ASSERT_NEXT(a_one_item, clock, reset, req_xfer, !req_ready, "second item taken")

   `BDQ_ASSERT(a_found_ok, clock, reset, found_ok, "found with data or bad status")

   `BDQ_ASSERT(a_reject_quiet, clock, reset, reject_quiet, "rejected operation carries data")

   `BDQ_ASSERT(a_full_count, clock, reset, full_count, "full status with wrong count")

   logic unused_req;
   assign unused_req = ^{req_action, req_value};

endmodule

bind byte_deque_with_search bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (.*);
